@@ src/i2crtm_pkg.sv @@
// Package for the I2C register transaction master.
// Holds the payload structs, the sequencer phase enum, register indexes and
// the byte-load helper. No dependencies.
package i2crtm_pkg;

  localparam int unsigned CfgIndexWidth   = 8;
  localparam int unsigned CfgDataWidth    = 16;
  localparam logic [15:0] HalfPeriodReset = 16'd5;
  localparam logic [7:0]  AckTimeoutReset = 8'd250;

  localparam logic [CfgIndexWidth-1:0] CfgHalfPeriod = 8'd0;
  localparam logic [CfgIndexWidth-1:0] CfgAckTimeout = 8'd1;

  localparam logic [7:0] AddrWriteMask = 8'hFE;
  localparam logic [7:0] AddrReadBit   = 8'h01;

  typedef enum logic [3:0] {
    PhIdle     = 4'd0,
    PhStart    = 4'd1,
    PhRsLow    = 4'd2,
    PhRsHigh   = 4'd3,
    PhBitLow   = 4'd4,
    PhBitHigh  = 4'd5,
    PhAckLow   = 4'd6,
    PhAckHigh  = 4'd7,
    PhMackLow  = 4'd8,
    PhMackHigh = 4'd9,
    PhStopLow  = 4'd10,
    PhStopHigh = 4'd11
  } phase_e;

  typedef struct packed {
    logic       kind;
    logic       is_read;
    logic [6:0] device_address;
    logic [7:0] register_pointer;
    logic [7:0] write_high;
    logic [7:0] write_low;
    logic       sda_in;
  } i2crtm_in_t;

  typedef struct packed {
    logic        scl_level;
    logic        sda_release;
    logic        busy_res;
    logic        done_res;
    logic        nack_error;
    logic [15:0] read_data;
  } i2crtm_out_t;

  // Pick the byte to shift out for a given byte slot of the transaction.
  function automatic logic [7:0] load_byte(input logic       is_read,
                                           input logic [6:0] addr,
                                           input logic [7:0] ptr,
                                           input logic [7:0] hi,
                                           input logic [7:0] lo,
                                           input logic [2:0] idx);
    logic [7:0] addr_byte;
    logic [7:0] b;
    addr_byte = {addr, 1'b0} & AddrWriteMask;
    unique case (idx)
      3'd0:    b = addr_byte;
      3'd1:    b = ptr;
      3'd2:    b = is_read ? (addr_byte | AddrReadBit) : hi;
      default: b = is_read ? 8'h00 : lo;
    endcase
    return b;
  endfunction

endpackage

@@ src/i2c_register_transaction_master.sv @@
// I2C register transaction master: bit sequencer, config registers and
// output register with one skid entry. Depends on i2crtm_pkg.
//
// Usage:
//   The input channel (in_valid_i / in_stall_o / in_data_i) carries either a
//   command transaction (kind = 0) that starts a register read or write, or a
//   tick transaction (kind = 1) that advances the SCL/SDA sequencer by one
//   time step and supplies the sampled SDA level. Commands arriving while a
//   transaction is in progress are dropped. Every input transaction yields
//   exactly one result on the output channel (out_valid_o / out_stall_i /
//   out_data_o): the line drive levels after that step, busy, and on the
//   step that completes the stop condition, done with error flag and read
//   word.
//   The result of an accepted transaction is registered. Throughput is one
//   transaction per clock while in_stall_o is low: the sequencer step is a
//   single pass of logic between the phase and result registers.
//   When the receiver stalls, the result register holds its value and a
//   second result lands in the skid entry; only with the skid entry full is
//   in_stall_o raised, and it drops once the receiver takes a result.
//   Configuration writes (index 0 half period ticks, index 1 ACK timeout)
//   are always ready; unknown indexes are dropped.
//   Reset puts the sequencer idle with both lines released, empties the
//   output side and loads the default half period and timeout.
module i2c_register_transaction_master
  import i2crtm_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  i2crtm_in_t               in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output i2crtm_out_t              out_data_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [CfgDataWidth-1:0]  cfg_data_i
);

  // Configuration registers
  logic [15:0] half_period_q;
  logic [7:0]  ack_timeout_q;

  // Sequencer state
  phase_e      phase_q, phase_d;
  logic [2:0]  byte_index_q, byte_index_d;
  logic [3:0]  bit_count_q, bit_count_d;
  logic [7:0]  shift_q, shift_d;
  logic [15:0] tick_count_q, tick_count_d;
  logic [7:0]  ack_wait_q, ack_wait_d;
  logic [15:0] read_word_q, read_word_d;
  logic        abort_q, abort_d;
  logic        cmd_read_q, cmd_read_d;
  logic [6:0]  cmd_addr_q, cmd_addr_d;
  logic [7:0]  cmd_ptr_q, cmd_ptr_d;
  logic [7:0]  cmd_high_q, cmd_high_d;
  logic [7:0]  cmd_low_q, cmd_low_d;

  // Step results
  logic        done_d, err_d;
  logic [15:0] rdata_d;
  i2crtm_out_t result;

  // Output register and skid entry
  logic        out_valid_q, skid_valid_q;
  i2crtm_out_t out_data_q, skid_data_q;

  logic in_accept, out_take;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign in_accept   = in_valid_i && !skid_valid_q;
  assign out_take    = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= HalfPeriodReset;
      ack_timeout_q <= AckTimeoutReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CfgHalfPeriod) begin
        half_period_q <= cfg_data_i;
      end else if (cfg_index_i == CfgAckTimeout) begin
        ack_timeout_q <= cfg_data_i[7:0];
      end
    end
  end

  // Next state: one sequencer step per accepted transaction.
  always_comb begin
    logic [15:0] tc_inc;
    logic [2:0]  idx_n;
    logic        rd_now;
    phase_d      = phase_q;
    byte_index_d = byte_index_q;
    bit_count_d  = bit_count_q;
    shift_d      = shift_q;
    tick_count_d = tick_count_q;
    ack_wait_d   = ack_wait_q;
    read_word_d  = read_word_q;
    abort_d      = abort_q;
    cmd_read_d   = cmd_read_q;
    cmd_addr_d   = cmd_addr_q;
    cmd_ptr_d    = cmd_ptr_q;
    cmd_high_d   = cmd_high_q;
    cmd_low_d    = cmd_low_q;
    done_d       = 1'b0;
    err_d        = 1'b0;
    rdata_d      = 16'h0000;
    tc_inc       = (tick_count_q < half_period_q) ? tick_count_q + 16'd1 : tick_count_q;
    idx_n        = byte_index_q + 3'd1;
    rd_now       = cmd_read_q && (byte_index_q >= 3'd3);

    if (!in_data_i.kind) begin
      if (phase_q == PhIdle) begin
        cmd_read_d   = in_data_i.is_read;
        cmd_addr_d   = in_data_i.device_address;
        cmd_ptr_d    = in_data_i.register_pointer;
        cmd_high_d   = in_data_i.write_high;
        cmd_low_d    = in_data_i.write_low;
        byte_index_d = 3'd0;
        bit_count_d  = 4'd0;
        shift_d      = 8'h00;
        tick_count_d = 16'd0;
        ack_wait_d   = 8'd0;
        read_word_d  = 16'h0000;
        abort_d      = 1'b0;
        phase_d      = PhStart;
      end
    end else if (phase_q != PhIdle) begin
      tick_count_d = tc_inc;
      if (tc_inc >= half_period_q) begin
        tick_count_d = 16'd0;
        unique case (phase_q)
          PhStart: begin
            shift_d     = load_byte(cmd_read_q, cmd_addr_q, cmd_ptr_q, cmd_high_q,
                                    cmd_low_q, byte_index_q);
            bit_count_d = 4'd0;
            phase_d     = PhBitLow;
          end
          PhRsLow:  phase_d = PhRsHigh;
          PhRsHigh: phase_d = PhStart;
          PhBitLow: phase_d = PhBitHigh;
          PhBitHigh: begin
            shift_d     = {shift_q[6:0], rd_now & in_data_i.sda_in};
            bit_count_d = bit_count_q + 4'd1;
            if (bit_count_d >= 4'd8) begin
              if (rd_now) begin
                if (byte_index_q == 3'd3) begin
                  read_word_d = {shift_d, read_word_q[7:0]};
                end else begin
                  read_word_d = {read_word_q[15:8], shift_d};
                end
                phase_d = PhMackLow;
              end else begin
                ack_wait_d = 8'd0;
                phase_d    = PhAckLow;
              end
            end else begin
              phase_d = PhBitLow;
            end
          end
          PhAckLow: phase_d = PhAckHigh;
          PhAckHigh: begin
            if (!in_data_i.sda_in) begin
              // ACK seen: advance to the next byte slot.
              byte_index_d = idx_n;
              if ((cmd_read_q && idx_n == 3'd2) ) begin
                phase_d = PhRsLow;
              end else if (!cmd_read_q && idx_n >= 3'd4) begin
                phase_d = PhStopLow;
              end else begin
                shift_d     = load_byte(cmd_read_q, cmd_addr_q, cmd_ptr_q, cmd_high_q,
                                        cmd_low_q, idx_n);
                bit_count_d = 4'd0;
                phase_d     = PhBitLow;
              end
            end else begin
              ack_wait_d = ack_wait_q + 8'd1;
              if (ack_wait_d >= ack_timeout_q || ack_wait_d == 8'd0) begin
                abort_d = 1'b1;
                phase_d = PhStopLow;
              end else begin
                // Re-sample on the very next tick.
                tick_count_d = half_period_q;
              end
            end
          end
          PhMackLow: phase_d = PhMackHigh;
          PhMackHigh: begin
            if (byte_index_q == 3'd3) begin
              byte_index_d = 3'd4;
              shift_d      = 8'h00;
              bit_count_d  = 4'd0;
              phase_d      = PhBitLow;
            end else begin
              phase_d = PhStopLow;
            end
          end
          PhStopLow: phase_d = PhStopHigh;
          default: begin
            done_d  = 1'b1;
            err_d   = abort_q;
            rdata_d = (cmd_read_q && !abort_q) ? read_word_q : 16'h0000;
            phase_d = PhIdle;
          end
        endcase
      end
    end
  end

  // Outputs: line drive from the state after the step.
  always_comb begin
    logic rd_next;
    rd_next            = cmd_read_d && (byte_index_d >= 3'd3);
    result.busy_res    = (phase_d != PhIdle);
    result.done_res    = done_d;
    result.nack_error  = err_d;
    result.read_data   = rdata_d;
    unique case (phase_d)
      PhStart:    begin result.scl_level = 1'b1; result.sda_release = 1'b0; end
      PhRsLow:    begin result.scl_level = 1'b0; result.sda_release = 1'b1; end
      PhRsHigh:   begin result.scl_level = 1'b1; result.sda_release = 1'b1; end
      PhBitLow:   begin result.scl_level = 1'b0; result.sda_release = rd_next | shift_d[7]; end
      PhBitHigh:  begin result.scl_level = 1'b1; result.sda_release = rd_next | shift_d[7]; end
      PhAckLow:   begin result.scl_level = 1'b0; result.sda_release = 1'b1; end
      PhAckHigh:  begin result.scl_level = 1'b1; result.sda_release = 1'b1; end
      PhMackLow:  begin
        result.scl_level = 1'b0; result.sda_release = (byte_index_d != 3'd3);
      end
      PhMackHigh: begin
        result.scl_level = 1'b1; result.sda_release = (byte_index_d != 3'd3);
      end
      PhStopLow:  begin result.scl_level = 1'b0; result.sda_release = 1'b0; end
      PhStopHigh: begin result.scl_level = 1'b1; result.sda_release = 1'b0; end
      default:    begin result.scl_level = 1'b1; result.sda_release = 1'b1; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhIdle;
      byte_index_q <= 3'd0;
      bit_count_q  <= 4'd0;
      shift_q      <= 8'h00;
      tick_count_q <= 16'd0;
      ack_wait_q   <= 8'd0;
      read_word_q  <= 16'h0000;
      abort_q      <= 1'b0;
      cmd_read_q   <= 1'b0;
      cmd_addr_q   <= 7'd0;
      cmd_ptr_q    <= 8'h00;
      cmd_high_q   <= 8'h00;
      cmd_low_q    <= 8'h00;
    end else if (in_accept) begin
      phase_q      <= phase_d;
      byte_index_q <= byte_index_d;
      bit_count_q  <= bit_count_d;
      shift_q      <= shift_d;
      tick_count_q <= tick_count_d;
      ack_wait_q   <= ack_wait_d;
      read_word_q  <= read_word_d;
      abort_q      <= abort_d;
      cmd_read_q   <= cmd_read_d;
      cmd_addr_q   <= cmd_addr_d;
      cmd_ptr_q    <= cmd_ptr_d;
      cmd_high_q   <= cmd_high_d;
      cmd_low_q    <= cmd_low_d;
    end
  end

  // Output side: result register backed by one skid entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (in_accept) begin
      if (!out_valid_q || out_take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_data_q <= skid_data_q;
      end
    end else if (in_accept) begin
      if (!out_valid_q || out_take) begin
        out_data_q <= result;
      end else begin
        skid_data_q <= result;
      end
    end
  end

endmodule

@@ verif/tb_i2c_register_transaction_master.sv @@
// Testbench for the I2C register transaction master: directed and random
// command/tick transactions checked against a cycle-free bus sequencer model.
// Depends on i2crtm_pkg and i2c_register_transaction_master.
module tb_i2c_register_transaction_master;
  import i2crtm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Register values after reset, and the first index that maps to no register.
  localparam logic [15:0] DefaultHalfPeriod = 16'd5;
  localparam logic [7:0]  DefaultAckTimeout = 8'd250;
  localparam int unsigned FirstUnusedIndex  = 2;

  // How the emulated slave answers during read data bits.
  typedef enum logic [1:0] {
    RxLow,
    RxHigh,
    RxRandom
  } rx_mode_e;

  logic                     clk         = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid    = 1'b0;
  i2crtm_in_t               in_data     = '0;
  logic                     out_stall   = 1'b0;
  logic                     cfg_valid   = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index   = '0;
  logic [CfgDataWidth-1:0]  cfg_data    = '0;
  logic                     in_stall;
  logic                     out_valid;
  i2crtm_out_t              out_data;
  logic                     cfg_ready;

  // Idle rates in percent for the sending and receiving sides.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  int unsigned items_sent     = 0;
  int unsigned mismatch_count = 0;

  // Line states still owed by the block, oldest first.
  i2crtm_out_t bus_levels_q[$];

  // Sequencer model state and its copy of the registers.
  logic [15:0] cfg_half  = DefaultHalfPeriod;
  logic [7:0]  cfg_ackto = DefaultAckTimeout;
  phase_e      st_phase  = PhIdle;
  logic [2:0]  st_byte   = '0;
  logic [3:0]  st_bits   = '0;
  logic [7:0]  st_shift  = '0;
  logic [15:0] st_ticks  = '0;
  logic [7:0]  st_ackw   = '0;
  logic [15:0] st_word   = '0;
  logic        st_abort  = 1'b0;
  logic        cmd_rd    = 1'b0;
  logic [6:0]  cmd_addr  = '0;
  logic [7:0]  cmd_ptr   = '0;
  logic [7:0]  cmd_hi    = '0;
  logic [7:0]  cmd_lo    = '0;

  i2c_register_transaction_master i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Sequencer model
  // ---------------------------------------------------------------------

  // True once the read address byte is done and the slave drives data.
  function automatic logic slave_drives_data();
    return cmd_rd && (st_byte >= 3'd3);
  endfunction

  // Load the byte for the current slot and start shifting it out MSB first.
  function automatic void load_tx_byte();
    case (st_byte)
      3'd0:    st_shift = {cmd_addr, 1'b0};
      3'd1:    st_shift = cmd_ptr;
      3'd2:    st_shift = cmd_rd ? {cmd_addr, 1'b1} : cmd_hi;
      default: st_shift = cmd_rd ? 8'h00 : cmd_lo;
    endcase
    st_bits  = '0;
    st_phase = PhBitLow;
  endfunction

  // Move on after a written byte got its ACK: repeated start after the
  // pointer on reads, stop after the low data byte on writes.
  function automatic void advance_byte();
    st_byte = st_byte + 3'd1;
    if (cmd_rd && st_byte == 3'd2) begin
      st_phase = PhRsLow;
    end else if (!cmd_rd && st_byte >= 3'd4) begin
      st_phase = PhStopLow;
    end else begin
      load_tx_byte();
    end
  endfunction

  // Apply one transaction to the model and return the line state after it.
  function automatic i2crtm_out_t step_bus(input i2crtm_in_t it);
    i2crtm_out_t r;
    logic        done;
    logic        err;
    logic [15:0] rdata;
    done  = 1'b0;
    err   = 1'b0;
    rdata = '0;
    if (!it.kind) begin
      // Commands only land while idle; a busy sequencer drops them.
      if (st_phase == PhIdle) begin
        cmd_rd   = it.is_read;
        cmd_addr = it.device_address;
        cmd_ptr  = it.register_pointer;
        cmd_hi   = it.write_high;
        cmd_lo   = it.write_low;
        st_byte  = '0;
        st_bits  = '0;
        st_shift = '0;
        st_ticks = '0;
        st_ackw  = '0;
        st_word  = '0;
        st_abort = 1'b0;
        st_phase = PhStart;
      end
    end else if (st_phase != PhIdle) begin
      if (st_ticks < cfg_half) st_ticks = st_ticks + 16'd1;
      if (st_ticks >= cfg_half) begin
        st_ticks = '0;
        case (st_phase)
          PhStart:   load_tx_byte();
          PhRsLow:   st_phase = PhRsHigh;
          PhRsHigh:  st_phase = PhStart;
          PhBitLow:  st_phase = PhBitHigh;
          PhBitHigh: begin
            st_shift = {st_shift[6:0], slave_drives_data() ? it.sda_in : 1'b0};
            st_bits  = st_bits + 4'd1;
            if (st_bits < 4'd8) begin
              st_phase = PhBitLow;
            end else if (slave_drives_data()) begin
              if (st_byte == 3'd3) st_word[15:8] = st_shift;
              else st_word[7:0] = st_shift;
              st_phase = PhMackLow;
            end else begin
              st_ackw  = '0;
              st_phase = PhAckLow;
            end
          end
          PhAckLow:  st_phase = PhAckHigh;
          PhAckHigh: begin
            if (!it.sda_in) begin
              advance_byte();
            end else begin
              // Count high samples; each later tick is one more sample.
              st_ackw = st_ackw + 8'd1;
              if (st_ackw >= cfg_ackto || st_ackw == 8'd0) begin
                st_abort = 1'b1;
                st_phase = PhStopLow;
              end else begin
                st_ticks = cfg_half;
              end
            end
          end
          PhMackLow:  st_phase = PhMackHigh;
          PhMackHigh: begin
            if (st_byte == 3'd3) begin
              st_byte = 3'd4;
              load_tx_byte();
            end else begin
              st_phase = PhStopLow;
            end
          end
          PhStopLow:  st_phase = PhStopHigh;
          default: begin
            done = 1'b1;
            err  = st_abort;
            if (cmd_rd && !st_abort) rdata = st_word;
            st_phase = PhIdle;
          end
        endcase
      end
    end

    r.scl_level   = 1'b1;
    r.sda_release = 1'b1;
    case (st_phase)
      PhStart: r.sda_release = 1'b0;
      PhRsLow, PhAckLow: r.scl_level = 1'b0;
      PhBitLow, PhBitHigh: begin
        r.scl_level   = (st_phase == PhBitHigh);
        r.sda_release = slave_drives_data() ? 1'b1 : st_shift[7];
      end
      PhMackLow, PhMackHigh: begin
        r.scl_level   = (st_phase == PhMackHigh);
        r.sda_release = (st_byte != 3'd3);
      end
      PhStopLow: begin
        r.scl_level   = 1'b0;
        r.sda_release = 1'b0;
      end
      PhStopHigh: r.sda_release = 1'b0;
      default: ;
    endcase
    r.busy_res   = (st_phase != PhIdle);
    r.done_res   = done;
    r.nack_error = err;
    r.read_data  = rdata;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------

  // Every field random, including those the block ignores for the kind.
  function automatic i2crtm_in_t rand_item();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(i2crtm_in_t)-1:0];
  endfunction

  // Send one transaction on the input channel; call at a falling edge.
  // Valid stays high on return so back-to-back items need no extra edge.
  task automatic send_item(input i2crtm_in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bus_levels_q.push_back(step_bus(it));
    items_sent++;
    @(negedge clk);
  endtask

  // Drop valid and hold until every owed result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (bus_levels_q.size() != 0);
  endtask

  // One register write handshake; leaves cfg_valid high.
  task automatic cfg_put(input logic [CfgIndexWidth-1:0] idx,
                         input logic [CfgDataWidth-1:0]  val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CfgHalfPeriod) cfg_half = val;
    else if (idx == CfgAckTimeout) cfg_ackto = val[7:0];
    @(negedge clk);
  endtask

  // Reprogram both registers once no transaction is in flight, plus a stray
  // write to an index that decodes to nothing.
  task automatic program_regs(input logic [15:0] half, input logic [15:0] ackto);
    wait_drained();
    cfg_put(CfgIndexWidth'($urandom_range(255, FirstUnusedIndex)), 16'($urandom));
    cfg_put(CfgHalfPeriod, half);
    cfg_put(CfgAckTimeout, ackto);
    cfg_valid <= 1'b0;
  endtask

  // Tick the sequencer until it goes idle, playing the slave: ACK low on
  // the sample point unless a miss is rolled, data bits per rx, and now
  // and then a command that the busy block must drop.
  task automatic clock_bus(input int unsigned miss_pct, input rx_mode_e rx,
                           input int unsigned cmd_pct);
    i2crtm_in_t it;
    while (st_phase != PhIdle) begin
      it = rand_item();
      if ($urandom_range(99) < cmd_pct) begin
        it.kind = 1'b0;
      end else begin
        it.kind = 1'b1;
        if (st_phase == PhAckHigh) begin
          it.sda_in = ($urandom_range(99) < miss_pct);
        end else if (st_phase == PhBitHigh && rx != RxRandom) begin
          it.sda_in = (rx == RxHigh);
        end
      end
      send_item(it);
    end
  endtask

  // Issue one command and run it to completion.
  task automatic run_transaction(input logic rd, input logic [6:0] addr,
                                 input logic [7:0] ptr, input logic [7:0] hi,
                                 input logic [7:0] lo, input int unsigned miss_pct,
                                 input rx_mode_e rx, input int unsigned cmd_pct);
    i2crtm_in_t it;
    it = rand_item();
    it.kind             = 1'b0;
    it.is_read          = rd;
    it.device_address   = addr;
    it.register_pointer = ptr;
    it.write_high       = hi;
    it.write_low        = lo;
    send_item(it);
    clock_bus(miss_pct, rx, cmd_pct);
  endtask

  task automatic idle_ticks(input int unsigned n);
    i2crtm_in_t it;
    repeat (n) begin
      it      = rand_item();
      it.kind = 1'b1;
      send_item(it);
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Idle ticks leave the lines released; a write starts at the reset half
  // period, then a short timing ends it with an abort on the first ACK.
  task automatic test_reset_defaults();
    i2crtm_in_t it;
    idle_ticks(4);
    it = rand_item();
    it.kind             = 1'b0;
    it.is_read          = 1'b0;
    it.device_address   = 7'h55;
    it.register_pointer = 8'hA5;
    it.write_high       = 8'h3C;
    it.write_low        = 8'hC3;
    send_item(it);
    idle_ticks(12);
    program_regs(16'd0, 16'd1);
    clock_bus(100, RxRandom, 0);
  endtask

  // Largest settings while idle, then zero half period and zero timeout:
  // one tick per half bit, and abort on the first high ACK sample.
  task automatic test_register_extremes();
    program_regs(16'hFFFF, 16'd255);
    idle_ticks(4);
    program_regs(16'h0000, 16'hAB00);
    run_transaction(1'b0, 7'h2A, 8'h11, 8'h22, 8'h33, 100, RxRandom, 0);
    run_transaction(1'b1, 7'h15, 8'hEE, 8'h00, 8'h00, 100, RxRandom, 0);
  endtask

  task automatic test_write_extremes();
    program_regs(16'd1, 16'd4);
    run_transaction(1'b0, 7'h7F, 8'hFF, 8'hFF, 8'hFF, 0, RxRandom, 0);
    run_transaction(1'b0, 7'h00, 8'h00, 8'h00, 8'h00, 100, RxRandom, 0);
  endtask

  // Read words of all ones and all zeros.
  task automatic test_read_extremes();
    program_regs(16'd1, 16'd4);
    run_transaction(1'b1, 7'h7F, 8'hFF, 8'h00, 8'h00, 0, RxHigh, 0);
    run_transaction(1'b1, 7'h00, 8'h00, 8'hFF, 8'hFF, 0, RxLow, 0);
  endtask

  // Short timeouts with ACKs that come late or never, on both directions.
  task automatic test_ack_timeout();
    program_regs(16'd0, 16'd1);
    run_transaction(1'b1, 7'h3A, 8'h10, 8'h00, 8'h00, 100, RxRandom, 0);
    program_regs(16'd0, 16'd3);
    run_transaction(1'b0, 7'h1E, 8'h02, 8'h81, 8'h7E, 40, RxRandom, 0);
  endtask

  // Commands mixed into the ticks of a running transaction must be dropped.
  task automatic test_busy_commands();
    program_regs(16'd0, 16'd8);
    run_transaction(1'b0, 7'h09, 8'hC0, 8'h0F, 8'hF0, 0, RxRandom, 30);
  endtask

  // Mostly well-formed transactions with random content and random slave
  // behavior; some bursts of raw noise; occasional retiming while idle.
  task automatic test_random(input int unsigned send_pct, input int unsigned recv_pct,
                             input int unsigned budget);
    int unsigned first;
    int unsigned roll;
    int unsigned half;
    int unsigned ackto;
    int unsigned miss;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    first = items_sent;
    while (items_sent - first < budget) begin
      roll = $urandom_range(99);
      if (roll < 20) begin
        roll  = $urandom_range(99);
        half  = (roll < 80) ? $urandom_range(1) : $urandom_range(3, 2);
        roll  = $urandom_range(99);
        ackto = (roll < 50) ? $urandom_range(3, 1) :
                (roll < 85) ? $urandom_range(30, 4) : 255;
        program_regs(16'(half), 16'(ackto));
      end
      roll = $urandom_range(9);
      miss = (roll < 5) ? 0 : (roll < 7) ? 10 : (roll < 9) ? 30 : 100;
      if ($urandom_range(99) < 10) begin
        repeat ($urandom_range(4, 1)) send_item(rand_item());
        // Finish whatever the noise may have started.
        clock_bus(miss, RxRandom, 3);
      end else begin
        run_transaction($urandom_range(1), 7'($urandom), 8'($urandom), 8'($urandom),
                        8'($urandom), miss, RxRandom, 3);
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Receiver and checker
  // ---------------------------------------------------------------------

  // Stall the result channel at random; update on the falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Compare every accepted result with the oldest owed line state.
  always @(posedge clk) begin : check_results
    i2crtm_out_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (bus_levels_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("%0t: result with nothing owed: %h", $realtime, out_data);
        end
      end else begin
        want = bus_levels_q.pop_front();
        if (want.scl_level !== out_data.scl_level ||
            want.sda_release !== out_data.sda_release ||
            want.busy_res !== out_data.busy_res ||
            want.done_res !== out_data.done_res ||
            want.nack_error !== out_data.nack_error ||
            want.read_data !== out_data.read_data) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: scl/sda/busy/done/nack/data want %b %b %b %b %b %h got %b %b %b %b %b %h",
                     $realtime, want.scl_level, want.sda_release, want.busy_res,
                     want.done_res, want.nack_error, want.read_data,
                     out_data.scl_level, out_data.sda_release, out_data.busy_res,
                     out_data.done_res, out_data.nack_error, out_data.read_data);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------

  initial begin
    // Hold reset low, then release it on a falling edge.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    // Directed part runs with the first idling mix.
    send_idle_pct  = 18;
    recv_stall_pct = 55;
    test_reset_defaults();
    test_register_extremes();
    test_write_extremes();
    test_read_extremes();
    test_ack_timeout();
    test_busy_commands();

    // Random part: receiver-heavy stalls, sender-heavy gaps, then full rate.
    test_random(18, 55, 20);
    test_random(55, 18, 20);
    test_random(0, 0, 20);

    // Drain, then let the output side run on idle to show stray results.
    wait_drained();
    repeat (4) @(negedge clk);
    if (mismatch_count == 0 && bus_levels_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
